// File: rtl/sdp_pkg.sv
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types, codes and a helper function for the step/direction pulse
// generator.
// ----------------------------------------------------------------------------
package sdp_pkg;

  localparam int unsigned PaddrWidth = 5;
  localparam int unsigned PdataWidth = 32;

  localparam logic [19:0] PeriodCap = 20'd1000000;

  // Function codes of an input beat.
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_ABSOLUTE = 3'd1;
  localparam logic [2:0] FUNC_RELATIVE = 3'd2;
  localparam logic [2:0] FUNC_STOP     = 3'd3;
  localparam logic [2:0] FUNC_LOAD     = 3'd4;

  // Motion sign codes.
  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_FWD  = 2'd1;
  localparam logic [1:0] SIGN_REV  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_DIR_SETUP      = 3'd0;
  localparam logic [2:0] REG_REVERSE_IDLE   = 3'd1;
  localparam logic [2:0] REG_PULSE_LOW      = 3'd2;
  localparam logic [2:0] REG_DEFAULT_PERIOD = 3'd3;
  localparam logic [2:0] REG_MIN_PERIOD     = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] DirSetupReset      = 16'd100;
  localparam logic [15:0] ReverseIdleReset   = 16'd1000;
  localparam logic [7:0]  PulseLowReset      = 8'd5;
  localparam logic [19:0] DefaultPeriodReset = 20'd1000;
  localparam logic [19:0] MinPeriodReset     = 20'd100;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] step_value;
    logic [19:0]        period_request;
  } in_item_t;

  typedef struct packed {
    logic               step_line_n;
    logic               dir_line;
    logic signed [31:0] position_now;
    logic               moving;
  } out_item_t;

  typedef struct packed {
    logic [15:0] dir_setup_ticks;
    logic [15:0] reverse_idle_ticks;
    logic [7:0]  pulse_low_ticks;
    logic [19:0] default_period_ticks;
    logic [19:0] min_period_ticks;
  } cfg_t;

  // Picks the step period for a start from idle.
  function automatic logic [19:0] choose_period(logic [19:0] req, logic [19:0] dflt,
                                                logic [19:0] min_p);
    logic [19:0] p;
    p = (req == 20'd0) ? dflt : req;
    if (p < min_p) p = min_p;
    if (p == 20'd0) p = 20'd1;
    if (p > PeriodCap) p = PeriodCap;
    return p;
  endfunction

endpackage

// File: rtl/sdp_cfg.sv
// ----------------------------------------------------------------------------
// sdp_cfg
// APB-style configuration register file for the pulse generator timing.
// ----------------------------------------------------------------------------
module sdp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdp_pkg::PaddrWidth-1:0]  paddr,
  input  logic [sdp_pkg::PdataWidth-1:0]  pwdata,
  output logic [sdp_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready,
  output sdp_pkg::cfg_t                   cfg_o
);

  sdp_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_setup_ticks      <= sdp_pkg::DirSetupReset;
      cfg_q.reverse_idle_ticks   <= sdp_pkg::ReverseIdleReset;
      cfg_q.pulse_low_ticks      <= sdp_pkg::PulseLowReset;
      cfg_q.default_period_ticks <= sdp_pkg::DefaultPeriodReset;
      cfg_q.min_period_ticks     <= sdp_pkg::MinPeriodReset;
    end else if (wr_en) begin
      case (reg_idx)
        sdp_pkg::REG_DIR_SETUP:      cfg_q.dir_setup_ticks      <= pwdata[15:0];
        sdp_pkg::REG_REVERSE_IDLE:   cfg_q.reverse_idle_ticks   <= pwdata[15:0];
        sdp_pkg::REG_PULSE_LOW:      cfg_q.pulse_low_ticks      <= pwdata[7:0];
        sdp_pkg::REG_DEFAULT_PERIOD: cfg_q.default_period_ticks <= pwdata[19:0];
        sdp_pkg::REG_MIN_PERIOD:     cfg_q.min_period_ticks     <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sdp_pkg::REG_DIR_SETUP:      prdata = {16'd0, cfg_q.dir_setup_ticks};
      sdp_pkg::REG_REVERSE_IDLE:   prdata = {16'd0, cfg_q.reverse_idle_ticks};
      sdp_pkg::REG_PULSE_LOW:      prdata = {24'd0, cfg_q.pulse_low_ticks};
      sdp_pkg::REG_DEFAULT_PERIOD: prdata = {12'd0, cfg_q.default_period_ticks};
      sdp_pkg::REG_MIN_PERIOD:     prdata = {12'd0, cfg_q.min_period_ticks};
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: rtl/sdp_core.sv
// ----------------------------------------------------------------------------
// sdp_core
// Motion state and the single-pass update that handles one tick or command.
// ----------------------------------------------------------------------------
module sdp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sdp_pkg::in_item_t   item_i,
  input  sdp_pkg::cfg_t       cfg_i,
  output sdp_pkg::out_item_t  result_o
);

  logic [31:0] position_q, position_d;
  logic [31:0] target_q, target_d;
  logic        running_q, running_d;
  logic [1:0]  sign_q, sign_d;
  logic        dir_q, dir_d;
  logic [15:0] guard_q, guard_d;
  logic [19:0] reload_q, reload_d;
  logic [19:0] period_q, period_d;
  logic [7:0]  pulse_q, pulse_d;

  logic [31:0] val;
  logic [31:0] delta;
  logic [1:0]  want;
  logic        level;
  logic        start;
  logic [19:0] new_period;

  assign val        = item_i.step_value;
  assign new_period = sdp_pkg::choose_period(item_i.period_request,
                                             cfg_i.default_period_ticks,
                                             cfg_i.min_period_ticks);

  always_comb begin
    position_d = position_q;
    target_d   = target_q;
    running_d  = running_q;
    sign_d     = sign_q;
    dir_d      = dir_q;
    guard_d    = guard_q;
    reload_d   = reload_q;
    period_d   = period_q;
    pulse_d    = pulse_q;
    delta      = target_q - position_q;
    want       = delta[31] ? sdp_pkg::SIGN_REV : sdp_pkg::SIGN_FWD;
    level      = (want == sdp_pkg::SIGN_REV);
    start      = 1'b0;

    case (item_i.func)
      sdp_pkg::FUNC_TICK: begin
        if (guard_q != 16'd0) guard_d = guard_q - 16'd1;
        if (pulse_q != 8'd0) pulse_d = pulse_q - 8'd1;
        if (running_q) begin
          if (period_q > 20'd1) begin
            period_d = period_q - 20'd1;
          end else begin
            period_d = reload_q;
            if (delta == 32'd0) begin
              running_d = 1'b0;
              sign_d    = sdp_pkg::SIGN_NONE;
              pulse_d   = 8'd0;
            end else if (sign_q != want) begin
              guard_d = (level != dir_q) ? cfg_i.reverse_idle_ticks
                                         : cfg_i.dir_setup_ticks;
              pulse_d = 8'd0;
              dir_d   = level;
              sign_d  = want;
            end else if (guard_d == 16'd0) begin
              pulse_d    = cfg_i.pulse_low_ticks;
              position_d = (want == sdp_pkg::SIGN_FWD) ? position_q + 32'd1
                                                       : position_q - 32'd1;
            end
          end
        end
      end
      sdp_pkg::FUNC_ABSOLUTE: begin
        target_d = val;
        start    = 1'b1;
      end
      sdp_pkg::FUNC_RELATIVE: begin
        if (val != 32'd0) begin
          target_d = position_q + val;
          start    = 1'b1;
        end
      end
      sdp_pkg::FUNC_STOP: begin
        target_d  = position_q;
        running_d = 1'b0;
        sign_d    = sdp_pkg::SIGN_NONE;
        pulse_d   = 8'd0;
      end
      sdp_pkg::FUNC_LOAD: begin
        running_d  = 1'b0;
        sign_d     = sdp_pkg::SIGN_NONE;
        pulse_d    = 8'd0;
        position_d = val;
        target_d   = val;
      end
      default: ;
    endcase

    if (start && (target_d != position_q) && !running_q) begin
      running_d = 1'b1;
      sign_d    = sdp_pkg::SIGN_NONE;
      guard_d   = 16'd0;
      reload_d  = new_period;
      period_d  = new_period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      target_q   <= '0;
      running_q  <= 1'b0;
      sign_q     <= sdp_pkg::SIGN_NONE;
      dir_q      <= 1'b1;
      guard_q    <= '0;
      reload_q   <= '0;
      period_q   <= '0;
      pulse_q    <= '0;
    end else if (fire_i) begin
      position_q <= position_d;
      target_q   <= target_d;
      running_q  <= running_d;
      sign_q     <= sign_d;
      dir_q      <= dir_d;
      guard_q    <= guard_d;
      reload_q   <= reload_d;
      period_q   <= period_d;
      pulse_q    <= pulse_d;
    end
  end

  assign result_o.step_line_n  = (pulse_d == 8'd0);
  assign result_o.dir_line     = dir_d;
  assign result_o.position_now = position_d;
  assign result_o.moving       = running_d || (target_d != position_d);

endmodule

// File: rtl/step_dir_pulse_generator.sv
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Step/direction pulse generator: one beat per microsecond tick or command,
// one result beat per input beat.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_ready_o, in_item_i         to block
//   output    out_valid_o, out_ready_i, out_item_o      from block
//   config    psel, penable, pwrite, paddr, pwdata,     APB-style, to block
//             prdata, pready
//
// A beat sits in the input register while the motion update runs on it,
// and its result is captured in the output register once that register is
// free, where it is presented until taken. One beat is taken every cycle
// while the output side keeps up. A stalled output holds both registers,
// and the input accepts again as soon as the output beat is taken.
// Reset clears the motion state, loads the register defaults and empties both
// registers.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sdp_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sdp_pkg::out_item_t              out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdp_pkg::PaddrWidth-1:0]  paddr,
  input  logic [sdp_pkg::PdataWidth-1:0]  pwdata,
  output logic [sdp_pkg::PdataWidth-1:0]  prdata,
  output logic                            pready
);

  sdp_pkg::cfg_t      cfg;
  sdp_pkg::in_item_t  item_q;
  sdp_pkg::out_item_t result;
  sdp_pkg::out_item_t out_q;
  logic               item_valid_q;
  logic               out_valid_q;
  logic               fire;

  assign fire        = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !item_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  sdp_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  sdp_core u_core (
    .clk_i,
    .rst_ni,
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Step/direction pulse generator testbench
// Sends tick and command beats through the valid/ready input and checks every
// status beat on the output against a cycle-free motion predictor kept in
// step with the accepted beats. The register file is rewritten between
// phases over the APB-style port, covering reset values, small periods and
// guards that exercise stepping and reversal, the widest values, and zero.
// The sender runs in random bursts and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sdp_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sdp_pkg::out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sdp_pkg::PaddrWidth-1:0] paddr = '0;
  logic [sdp_pkg::PdataWidth-1:0] pwdata = '0;
  logic [sdp_pkg::PdataWidth-1:0] prdata;
  logic pready;

  step_dir_pulse_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sdp_pkg::in_item_t beat_queue[$];
  sdp_pkg::out_item_t status_expected[$];
  int queued_total = 0;
  int taken_total = 0;
  int mismatch_count = 0;
  logic in_fire = 1'b0;

  // Motion predictor state and its copy of the registers.
  sdp_pkg::cfg_t cfg_model;
  logic [31:0] pos_q, tgt_q;
  logic run_q, dir_q;
  logic [1:0] sign_q;
  logic [15:0] guard_q;
  logic [19:0] reload_q, left_q;
  logic [7:0] pulse_q;

  function automatic void reset_motion();
    cfg_model.dir_setup_ticks = sdp_pkg::DirSetupReset;
    cfg_model.reverse_idle_ticks = sdp_pkg::ReverseIdleReset;
    cfg_model.pulse_low_ticks = sdp_pkg::PulseLowReset;
    cfg_model.default_period_ticks = sdp_pkg::DefaultPeriodReset;
    cfg_model.min_period_ticks = sdp_pkg::MinPeriodReset;
    pos_q = '0;
    tgt_q = '0;
    run_q = 1'b0;
    sign_q = sdp_pkg::SIGN_NONE;
    dir_q = 1'b1;
    guard_q = '0;
    reload_q = '0;
    left_q = '0;
    pulse_q = '0;
  endfunction

  function automatic void halt_motion();
    tgt_q = pos_q;
    run_q = 1'b0;
    sign_q = sdp_pkg::SIGN_NONE;
    pulse_q = '0;
  endfunction

  function automatic void start_motion(logic [19:0] req);
    logic [19:0] p;
    if (tgt_q == pos_q || run_q) return;
    p = (req == 20'd0) ? cfg_model.default_period_ticks : req;
    if (p < cfg_model.min_period_ticks) p = cfg_model.min_period_ticks;
    if (p == 20'd0) p = 20'd1;
    if (p > sdp_pkg::PeriodCap) p = sdp_pkg::PeriodCap;
    run_q = 1'b1;
    sign_q = sdp_pkg::SIGN_NONE;
    guard_q = '0;
    reload_q = p;
    left_q = p;
  endfunction

  function automatic void period_expired();
    logic [31:0] delta;
    logic [1:0] want;
    logic level;
    delta = tgt_q - pos_q;
    if (delta == 32'd0) begin
      run_q = 1'b0;
      sign_q = sdp_pkg::SIGN_NONE;
      pulse_q = '0;
      return;
    end
    want = delta[31] ? sdp_pkg::SIGN_REV : sdp_pkg::SIGN_FWD;
    if (sign_q != want) begin
      level = (want == sdp_pkg::SIGN_REV);
      guard_q = (level != dir_q) ? cfg_model.reverse_idle_ticks : cfg_model.dir_setup_ticks;
      pulse_q = '0;
      dir_q = level;
      sign_q = want;
      return;
    end
    if (guard_q != 16'd0) return;
    pulse_q = cfg_model.pulse_low_ticks;
    pos_q = (want == sdp_pkg::SIGN_FWD) ? pos_q + 32'd1 : pos_q - 32'd1;
  endfunction

  function automatic sdp_pkg::out_item_t advance_motion(sdp_pkg::in_item_t beat);
    sdp_pkg::out_item_t s;
    case (beat.func)
      sdp_pkg::FUNC_TICK: begin
        if (guard_q != 16'd0) guard_q--;
        if (pulse_q != 8'd0) pulse_q--;
        if (run_q) begin
          if (left_q > 20'd1) left_q--;
          else begin
            left_q = reload_q;
            period_expired();
          end
        end
      end
      sdp_pkg::FUNC_ABSOLUTE: begin
        tgt_q = beat.step_value;
        start_motion(beat.period_request);
      end
      sdp_pkg::FUNC_RELATIVE: begin
        if (beat.step_value != 32'sd0) begin
          tgt_q = pos_q + beat.step_value;
          start_motion(beat.period_request);
        end
      end
      sdp_pkg::FUNC_STOP: halt_motion();
      sdp_pkg::FUNC_LOAD: begin
        halt_motion();
        pos_q = beat.step_value;
        tgt_q = beat.step_value;
      end
      default: ;
    endcase
    s.step_line_n = (pulse_q == 8'd0);
    s.dir_line = dir_q;
    s.position_now = pos_q;
    s.moving = run_q || (tgt_q != pos_q);
    return s;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    sdp_pkg::out_item_t want_s;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      status_expected.push_back(advance_motion(in_item_i));
      taken_total++;
    end
    if (out_valid_o && out_ready_i) begin
      if (status_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("status beat with nothing expected: %h", out_item_o);
      end else begin
        want_s = status_expected.pop_front();
        if (out_item_o.step_line_n !== want_s.step_line_n)
          report_field("step_line_n", want_s.step_line_n, out_item_o.step_line_n);
        if (out_item_o.dir_line !== want_s.dir_line)
          report_field("dir_line", want_s.dir_line, out_item_o.dir_line);
        if (out_item_o.position_now !== want_s.position_now)
          report_field("position_now", want_s.position_now, out_item_o.position_now);
        if (out_item_o.moving !== want_s.moving)
          report_field("moving", want_s.moving, out_item_o.moving);
      end
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        in_item_i <= beat_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  rx_mode_e rx_mode = RX_OPEN;
  int rx_hold = 0;

  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_hold = $urandom_range(20, 150);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_OPEN: out_ready_i <= 1'b1;
      RX_COIN: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic add_beat(logic [2:0] func, logic [31:0] value, logic [19:0] req);
    sdp_pkg::in_item_t b;
    b.func = func;
    b.step_value = value;
    b.period_request = req;
    beat_queue.push_back(b);
    queued_total++;
  endtask

  task automatic drain();
    while (taken_total != queued_total || status_expected.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic sdp_pkg::cfg_t make_cfg(int unsigned ds, int unsigned ri,
                                             int unsigned pl, int unsigned dp,
                                             int unsigned mp);
    sdp_pkg::cfg_t c;
    c.dir_setup_ticks = 16'(ds);
    c.reverse_idle_ticks = 16'(ri);
    c.pulse_low_ticks = 8'(pl);
    c.default_period_ticks = 20'(dp);
    c.min_period_ticks = 20'(mp);
    return c;
  endfunction

  task automatic write_config(sdp_pkg::cfg_t c);
    apb_write(sdp_pkg::REG_DIR_SETUP, 32'(c.dir_setup_ticks));
    apb_write(sdp_pkg::REG_REVERSE_IDLE, 32'(c.reverse_idle_ticks));
    apb_write(sdp_pkg::REG_PULSE_LOW, 32'(c.pulse_low_ticks));
    apb_write(sdp_pkg::REG_DEFAULT_PERIOD, 32'(c.default_period_ticks));
    apb_write(sdp_pkg::REG_MIN_PERIOD, 32'(c.min_period_ticks));
    cfg_model = c;
  endtask

  // Mostly ticks around a home position, with targets and moves a few steps
  // away so that direction changes, guards and pulses happen often.
  task automatic fill_random(int count, logic [31:0] home, int unsigned span);
    int r;
    logic [19:0] req;
    logic [31:0] value;
    add_beat(sdp_pkg::FUNC_LOAD, home, 20'($urandom_range(0, 1000000)));
    for (int i = 1; i < count; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: req = 20'd0;
        8, 9, 10, 11, 12, 13, 14, 15, 16: req = 20'($urandom_range(1, 8));
        default: req = 20'($urandom_range(0, 1000000));
      endcase
      value = home + 32'($urandom_range(0, 2 * span)) - 32'(span);
      if (r < 62) begin
        add_beat(sdp_pkg::FUNC_TICK, $urandom, 20'($urandom_range(0, 1000000)));
      end else if (r < 76) begin
        add_beat(sdp_pkg::FUNC_ABSOLUTE, (r == 75) ? 32'($urandom) : value, req);
      end else if (r < 90) begin
        value = ($urandom_range(0, 9) == 0) ? 32'd0
                : 32'($urandom_range(0, 2 * span)) - 32'(span);
        add_beat(sdp_pkg::FUNC_RELATIVE, value, req);
      end else if (r < 94) begin
        add_beat(sdp_pkg::FUNC_STOP, $urandom, req);
      end else if (r < 98) begin
        add_beat(sdp_pkg::FUNC_LOAD, (r == 97) ? 32'($urandom) : value, req);
      end else begin
        add_beat(3'(sdp_pkg::FUNC_LOAD + 3'($urandom_range(1, 3))), $urandom, req);
      end
    end
  endtask

  initial begin
    logic [31:0] home;
    reset_motion();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fill_random(120, 32'd0, 4);
    drain();

    write_config(make_cfg(1, 2, 2, 3, 1));
    add_beat(sdp_pkg::FUNC_TICK, 32'hFFFF_FFFF, 20'd1000000);
    add_beat(sdp_pkg::FUNC_LOAD + 3'd1, 32'h1234_5678, 20'd7);
    add_beat(sdp_pkg::FUNC_LOAD + 3'd2, 32'h8000_0000, 20'd0);
    add_beat(sdp_pkg::FUNC_LOAD + 3'd3, 32'h7FFF_FFFF, 20'd1);
    add_beat(sdp_pkg::FUNC_LOAD, 32'h7FFF_FFFF, 20'd0);
    add_beat(sdp_pkg::FUNC_RELATIVE, 32'd0, 20'd1);
    add_beat(sdp_pkg::FUNC_ABSOLUTE, 32'h8000_0000, 20'd1);
    repeat (5) add_beat(sdp_pkg::FUNC_TICK, 32'd0, 20'd0);
    add_beat(sdp_pkg::FUNC_LOAD, 32'h8000_0000, 20'd0);
    add_beat(sdp_pkg::FUNC_RELATIVE, 32'hFFFF_FFFF, 20'd1);
    repeat (3) add_beat(sdp_pkg::FUNC_TICK, 32'd0, 20'd0);
    add_beat(sdp_pkg::FUNC_RELATIVE, 32'd3, 20'd1000000);
    add_beat(sdp_pkg::FUNC_TICK, 32'd0, 20'd0);
    add_beat(sdp_pkg::FUNC_STOP, 32'd0, 20'd0);
    add_beat(sdp_pkg::FUNC_ABSOLUTE, 32'h7FFF_FFFF, 20'd1000000);
    add_beat(sdp_pkg::FUNC_TICK, 32'd0, 20'd0);
    add_beat(sdp_pkg::FUNC_STOP, 32'hFFFF_FFFF, 20'd1000000);
    drain();

    for (int n = 0; n < 5; n++) begin
      write_config(make_cfg($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 4),
                            $urandom_range(1, 8), $urandom_range(1, 5)));
      case ($urandom_range(0, 3))
        0: home = 32'd0;
        1: home = 32'h7FFF_FFF8;
        2: home = 32'h8000_0004;
        default: home = $urandom;
      endcase
      fill_random(170, home, 6);
      drain();
    end

    write_config(make_cfg(65535, 65535, 255, 1000000, 1000000));
    fill_random(40, $urandom, 4);
    drain();

    write_config(make_cfg(1, 1, 1, 1, 1));
    fill_random(150, 32'h7FFF_FFFC, 5);
    drain();

    write_config(make_cfg(0, 0, 0, 0, 0));
    fill_random(150, 32'h8000_0003, 5);
    drain();

    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && status_expected.size() == 0) begin
      $display("[step_dir_pulse_generator] OK");
    end else begin
      $display("[step_dir_pulse_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[step_dir_pulse_generator] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sdp_pkg.sv
rtl/sdp_cfg.sv
rtl/sdp_core.sv
rtl/step_dir_pulse_generator.sv
tb/tb.sv
